// File: rtl/core/bme_pkg.sv
package bme_pkg;

	// Defaults for the top-level parameters
	localparam int NUM_PARAMS_DEF = 16;
	localparam int POT_BITS_DEF   = 10;

	// Fixed field widths
	localparam int BTN_W   = 4;
	localparam int POT_W   = 10;
	localparam int LED_W   = 4;
	localparam int INDEX_W = 4;
	localparam int ENTRY_W = 10;
	localparam int SHOW_W  = 16;

	// Value counter wraps modulo 16
	localparam int CNT_W = 4;

	// Display constants
	localparam int POT_SHOW_SHIFT = 6;
	localparam logic [SHOW_W-1:0] LED_TOP_THRESH = SHOW_W'(8);

	// Winning press, highest-numbered rising button
	typedef enum logic [2:0] {
		PRESS_B0   = 3'd0,
		PRESS_B1   = 3'd1,
		PRESS_B2   = 3'd2,
		PRESS_B3   = 3'd3,
		PRESS_NONE = 3'd5
	} press_t;

	// Per-item decisions from the mode controller to the table
	typedef struct packed {
		logic select_mode; // mode after this request
		logic wr_en;       // table entry at the index is written
		logic use_pot;     // write data is the pot reading, else the counter
		logic shift_show;  // button 3 in edit mode: display entry >> 6
	} bme_ctl_t;

endpackage

// File: rtl/core/button_menu_parameter_editor.sv
// An accepted request passes the input register, then the result register, to m_tvalid.
// Throughput: one request per cycle without backpressure; each register stages one.
// Backpressure on m_tready stalls the input side once both stages are full.
// Reset (arst_n low, asynchronous): select mode, index 0, counter 0, prior levels 0,
// all table entries cleared in flip-flops at once; no clearing pass afterwards.
module button_menu_parameter_editor #(
	parameter int NUM_PARAMS = bme_pkg::NUM_PARAMS_DEF,
	parameter int POT_BITS   = bme_pkg::POT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata, from bit 0: button_levels[3:0], pot_sample[13:4], zero fill [15:14]
	input  logic [15:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// m_tdata, from bit 0: led_bits[3:0], ramp_on[4], selected_index[8:5],
	// selected_entry[18:9], zero fill [23:19]
	output logic [23:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready
);
	import bme_pkg::*;

	localparam int IDX_W = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
	// stored entries keep the pot bits the port carries, at most POT_BITS of them
	localparam int TBL_W = (POT_BITS < POT_W) ? POT_BITS : POT_W;

	// Input stage
	logic             valid_s1;
	logic [BTN_W-1:0] levels_s1;
	logic [POT_W-1:0] pot_s1;

	// Result stage
	logic                valid_s2;
	logic [LED_W-1:0]    led_s2;
	logic                ramp_s2;
	logic [INDEX_W-1:0]  index_s2;
	logic [ENTRY_W-1:0]  entry_s2;

	logic             advance;
	logic [IDX_W-1:0] idx_d;
	logic [CNT_W-1:0] cnt_d;
	bme_ctl_t         ctl;
	logic [TBL_W-1:0] entry;

	// Display path
	logic [TBL_W-1:0]         entry_shown;
	logic [SHOW_W-1:0]        shown;
	logic [LED_W-1:0]         led_d;
	logic [IDX_W+INDEX_W-1:0] idx_ext;

	// A request moves from the input stage into the result stage whenever
	// the result stage is empty or is being taken this cycle.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			levels_s1 <= s_tdata[BTN_W-1:0];
			pot_s1    <= s_tdata[BTN_W+POT_W-1:BTN_W];
		end
	end

	// Mode, index and counter; all state commits on advance
	bme_ctrl #(
		.NUM_PARAMS(NUM_PARAMS),
		.IDX_W     (IDX_W)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.levels(levels_s1),
		.idx_d (idx_d),
		.cnt_d (cnt_d),
		.ctl   (ctl)
	);

	// Parameter table, read at the index after this request
	bme_table #(
		.NUM_PARAMS(NUM_PARAMS),
		.IDX_W     (IDX_W),
		.TBL_W     (TBL_W)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.ctl   (ctl),
		.idx   (idx_d),
		.cnt   (cnt_d),
		.pot   (pot_s1[TBL_W-1:0]),
		.entry (entry)
	);

	// Select mode shows the index, edit mode the entry (>> 6 on a button-3 store).
	// LEDs 0..2 are the low bits of the shown value, LED 3 means 8 or more.
	always_comb begin
		entry_shown = ctl.shift_show ? (entry >> POT_SHOW_SHIFT) : entry;
		shown       = ctl.select_mode ? SHOW_W'(idx_d) : SHOW_W'(entry_shown);
		led_d       = {shown >= LED_TOP_THRESH, shown[2:0]};
		idx_ext     = {{INDEX_W{1'b0}}, idx_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_s2   <= led_d;
			ramp_s2  <= ctl.select_mode;
			index_s2 <= idx_ext[INDEX_W-1:0];
			entry_s2 <= ENTRY_W'(entry);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, entry_s2, index_s2, ramp_s2, led_s2};

`ifndef NO_ASSERTIONS
	// In select mode the LEDs mirror the index bits exactly
	a_select_leds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[4]) |-> (m_tdata[3:0] == m_tdata[8:5]))
		else $error("select-mode LEDs differ from index");

	// An advancing request always lands in the result stage
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("advanced request lost");

	// The index never leaves the table range
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (int'(idx_d) < NUM_PARAMS))
		else $error("parameter index out of range");

	// The input stage never refuses while empty
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled while empty");
`endif

endmodule

// File: rtl/core/bme_ctrl.sv
module bme_ctrl #(
	parameter int NUM_PARAMS = bme_pkg::NUM_PARAMS_DEF,
	parameter int IDX_W      = $clog2(NUM_PARAMS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [bme_pkg::BTN_W-1:0] levels,
	output logic [IDX_W-1:0]        idx_d,
	output logic [bme_pkg::CNT_W-1:0] cnt_d,
	output bme_pkg::bme_ctl_t       ctl
);
	import bme_pkg::*;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_PARAMS - 1);

	logic [BTN_W-1:0] prev_q;
	logic             sel_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [BTN_W-1:0] rising;
	press_t           code;
	logic             sel_d;

	// rising edges against last request, highest button wins
	always_comb begin
		rising = levels & ~prev_q;
		if (rising[3]) begin
			code = PRESS_B3;
		end else if (rising[2]) begin
			code = PRESS_B2;
		end else if (rising[1]) begin
			code = PRESS_B1;
		end else if (rising[0]) begin
			code = PRESS_B0;
		end else begin
			code = PRESS_NONE;
		end
	end

	always_comb begin
		sel_d       = sel_q;
		idx_d       = idx_q;
		cnt_d       = cnt_q;
		ctl.wr_en   = 1'b0;
		ctl.use_pot = 1'b0;
		if (sel_q) begin
			case (code)
				PRESS_B0: begin
					sel_d = 1'b0;
					cnt_d = '0;
				end
				PRESS_B1: idx_d = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
				PRESS_B2: idx_d = (idx_q == '0) ? IDX_LAST : idx_q - 1'b1;
				default: ;
			endcase
		end else begin
			case (code)
				PRESS_B0: begin
					sel_d = 1'b1;
					idx_d = '0;
				end
				PRESS_B1: begin
					cnt_d     = cnt_q + 1'b1;
					ctl.wr_en = 1'b1;
				end
				PRESS_B2: begin
					cnt_d     = cnt_q - 1'b1;
					ctl.wr_en = 1'b1;
				end
				PRESS_B3: begin
					ctl.wr_en   = 1'b1;
					ctl.use_pot = 1'b1;
				end
				default: ;
			endcase
		end
		ctl.select_mode = sel_d;
		ctl.shift_show  = !sel_q && (code == PRESS_B3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sel_q  <= 1'b1;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (step) begin
			prev_q <= levels;
			sel_q  <= sel_d;
			idx_q  <= idx_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

// File: rtl/core/bme_table.sv
module bme_table #(
	parameter int NUM_PARAMS = bme_pkg::NUM_PARAMS_DEF,
	parameter int IDX_W      = $clog2(NUM_PARAMS),
	parameter int TBL_W      = bme_pkg::POT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  bme_pkg::bme_ctl_t         ctl,
	input  logic [IDX_W-1:0]          idx,
	input  logic [bme_pkg::CNT_W-1:0] cnt,
	input  logic [TBL_W-1:0]          pot,
	output logic [TBL_W-1:0]          entry
);
	import bme_pkg::*;

	logic [TBL_W-1:0] tbl_q [NUM_PARAMS];
	logic [TBL_W-1:0] wdata;

	assign wdata = ctl.use_pot ? pot : TBL_W'(cnt);
	// writes only happen in edit mode, where the index holds: bypass the new value
	assign entry = ctl.wr_en ? wdata : tbl_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PARAMS; k++) begin
				tbl_q[k] <= '0;
			end
		end else if (step && ctl.wr_en) begin
			tbl_q[idx] <= wdata;
		end
	end

endmodule
